// ===== rtl/subnet_split_negotiator_core_defines.svh =====
// Assertion macros for the subnet split negotiator checker.
// Depends on clk_i and rst_ni in the scope where a macro is used.
`ifndef SUBNET_SPLIT_NEGOTIATOR_CORE_DEFINES_SVH
`define SUBNET_SPLIT_NEGOTIATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssn check failed");

// next-cycle implication
`define SSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssn check failed");

`endif

// ===== rtl/ssn_pkg.sv =====
// Shared constants for the subnet split negotiator: parameter defaults, port widths,
// request op codes, status codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ssn_pkg;

  localparam int PEER_SLOTS_DEF     = 4;
  localparam int MAX_ADDR_BYTES_DEF = 8;
  localparam int MAX_DOWNSTREAM_DEF = 8;

  localparam int PREFIX_W  = 64;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;

  localparam logic OP_ANNOUNCE = 1'b0;
  localparam logic OP_TIMEOUT  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [2:0] REG_OWN_ADDRESS     = 3'd0;
  localparam logic [2:0] REG_ADDRESS_LENGTH  = 3'd1;
  localparam logic [2:0] REG_LOCAL_SUBNETS   = 3'd2;
  localparam logic [2:0] REG_UPSTREAM_PREFIX = 3'd3;
  localparam logic [2:0] REG_PREFIX_LENGTH   = 3'd4;

  localparam logic [3:0] ADDRESS_LENGTH_RST = 4'd8;
  localparam logic [3:0] LOCAL_SUBNETS_RST  = 4'd1;
  localparam logic [6:0] PREFIX_LENGTH_RST  = 7'd48;

endpackage

// ===== rtl/subnet_split_negotiator_core.sv =====
// Announcement: after accept, one peer slot is compared per cycle in the scan state,
// then the update state; a duplicate ends at the matching slot. Timeout: a setup
// state, then one result per cycle through the output register unless the receiver
// stalls, local_subnets results clamped to 1..MAX_DOWNSTREAM (one on error); next
// request taken after the last is loaded. Reset: registers to their documented
// values, peer table and start index zero, subnet total one. Depends on ssn_pkg.
`timescale 1ns / 1ps

module subnet_split_negotiator_core
  import ssn_pkg::*;
#(
  parameter int PEER_SLOTS     = PEER_SLOTS_DEF,
  parameter int MAX_ADDR_BYTES = MAX_ADDR_BYTES_DEF,
  parameter int MAX_DOWNSTREAM = MAX_DOWNSTREAM_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [63:0]         peer_address_i,
  input  logic                peer_accepted_i,
  input  logic [7:0]          remote_subnets_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                status_o,
  output logic [63:0]         sub_prefix_o,
  output logic [6:0]          sub_prefix_length_o,
  output logic [7:0]          subnet_index_o,
  output logic                last_o
);

  localparam int ADDR_W  = 8 * MAX_ADDR_BYTES;
  localparam int SLOT_IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [63:0] own_address_q;
  logic [3:0]  address_length_q;
  logic [3:0]  local_subnets_q;
  logic [63:0] upstream_prefix_q;
  logic [6:0]  prefix_length_q;

  logic [2:0]  state_q, state_d;
  logic [ADDR_W-1:0] slot_q [PEER_SLOTS];
  logic [ADDR_W-1:0] slot_d [PEER_SLOTS];
  logic [7:0]  total_q, total_d;
  logic [7:0]  start_q, start_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]  rem_q, rem_d;
  logic [SLOT_IW-1:0] scan_q, scan_d;
  logic        empty_vld_q, empty_vld_d;
  logic [SLOT_IW-1:0] empty_idx_q, empty_idx_d;
  logic [63:0] base_q, base_d;
  logic [3:0]  bits_q, bits_d;
  logic [6:0]  nl_q, nl_d;
  logic        err_q, err_d;
  logic [7:0]  idx_q, idx_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  n_q, n_d;

  logic        out_valid_q, out_valid_d;
  logic        status_q, status_d;
  logic [63:0] sub_prefix_q, sub_prefix_d;
  logic [6:0]  sub_len_q, sub_len_d;
  logic [7:0]  sub_idx_q, sub_idx_d;
  logic        last_q, last_d;

  logic [3:0]  addr_bytes;
  logic [3:0]  iface_cnt;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] slot_m;
  logic [ADDR_W-1:0] own_m;
  logic [3:0]  total_bits;
  logic [7:0]  nl_wide;
  logic [7:0]  idx_next;
  logic [7:0]  field_mask;
  logic [7:0]  field;
  logic        cfg_wr;
  logic        in_acc;
  logic        out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q     <= '0;
      address_length_q  <= ADDRESS_LENGTH_RST;
      local_subnets_q   <= LOCAL_SUBNETS_RST;
      upstream_prefix_q <= '0;
      prefix_length_q   <= PREFIX_LENGTH_RST;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_OWN_ADDRESS:     own_address_q     <= pwdata;
        REG_ADDRESS_LENGTH:  address_length_q  <= pwdata[3:0];
        REG_LOCAL_SUBNETS:   local_subnets_q   <= pwdata[3:0];
        REG_UPSTREAM_PREFIX: upstream_prefix_q <= pwdata;
        REG_PREFIX_LENGTH:   prefix_length_q   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_OWN_ADDRESS:     prdata = own_address_q;
      REG_ADDRESS_LENGTH:  prdata = {60'd0, address_length_q};
      REG_LOCAL_SUBNETS:   prdata = {60'd0, local_subnets_q};
      REG_UPSTREAM_PREFIX: prdata = upstream_prefix_q;
      REG_PREFIX_LENGTH:   prdata = {57'd0, prefix_length_q};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (address_length_q == 4'd0) begin
      addr_bytes = 4'd1;
    end else if (32'(address_length_q) > MAX_ADDR_BYTES) begin
      addr_bytes = 4'(MAX_ADDR_BYTES);
    end else begin
      addr_bytes = address_length_q;
    end
    if (local_subnets_q == 4'd0) begin
      iface_cnt = 4'd1;
    end else if (32'(local_subnets_q) > MAX_DOWNSTREAM) begin
      iface_cnt = 4'(MAX_DOWNSTREAM);
    end else begin
      iface_cnt = local_subnets_q;
    end
    for (int b = 0; b < MAX_ADDR_BYTES; b++) begin
      mask[8*b +: 8] = {8{b < 32'(addr_bytes)}};
    end
    total_bits = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (total_q[i]) total_bits = 4'(i + 1);
    end
  end

  assign slot_m     = slot_q[scan_q] & mask;
  assign own_m      = own_address_q[ADDR_W-1:0] & mask;
  assign nl_wide    = {1'b0, prefix_length_q} + {4'd0, total_bits};
  assign idx_next   = idx_q + 8'd1;
  assign field_mask = 8'((16'd1 << bits_q) - 16'd1);
  assign field      = idx_next & field_mask;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    total_d      = total_q;
    start_d      = start_q;
    addr_d       = addr_q;
    rem_d        = rem_q;
    scan_d       = scan_q;
    empty_vld_d  = empty_vld_q;
    empty_idx_d  = empty_idx_q;
    base_d       = base_q;
    bits_d       = bits_q;
    nl_d         = nl_q;
    err_d        = err_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    sub_prefix_d = sub_prefix_q;
    sub_len_d    = sub_len_q;
    sub_idx_d    = sub_idx_q;
    last_d       = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_TIMEOUT) begin
            state_d = S_SETUP;
          end else if (peer_accepted_i) begin
            addr_d      = peer_address_i[ADDR_W-1:0] & mask;
            rem_d       = remote_subnets_i;
            scan_d      = '0;
            empty_vld_d = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (slot_m == '0) begin
          empty_vld_d = 1'b1;
          empty_idx_d = scan_q;
        end
        if (slot_m != '0 && slot_m == addr_q) begin
          state_d = S_IDLE;
        end else if (scan_q == SLOT_IW'(PEER_SLOTS - 1)) begin
          state_d = S_UPD;
        end else begin
          scan_d = scan_q + SLOT_IW'(1);
        end
      end
      S_UPD: begin
        if (empty_vld_q) begin
          slot_d[empty_idx_q] = (slot_q[empty_idx_q] & ~mask) | addr_q;
        end
        if (own_m != addr_q) begin
          total_d = total_q + rem_q;
          if (own_m > addr_q) start_d = start_q + rem_q;
        end
        state_d = S_IDLE;
      end
      S_SETUP: begin
        bits_d  = total_bits;
        nl_d    = nl_wide[6:0];
        err_d   = (total_bits == 4'd0) || (nl_wide > 8'd64);
        base_d  = (prefix_length_q == 7'd0) ? 64'd0 :
                  (upstream_prefix_q & (~64'd0 << (7'd64 - prefix_length_q)));
        idx_d   = start_q;
        cnt_d   = 4'd0;
        n_d     = iface_cnt;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            status_d     = STATUS_ERR;
            sub_prefix_d = '0;
            sub_len_d    = '0;
            sub_idx_d    = '0;
            last_d       = 1'b1;
          end else begin
            status_d     = STATUS_OK;
            sub_prefix_d = base_q | ({56'd0, field} << (7'd64 - nl_q));
            sub_len_d    = nl_q;
            sub_idx_d    = idx_next;
            last_d       = (cnt_q + 4'd1 == n_q);
            idx_d        = idx_next;
            cnt_d        = cnt_q + 4'd1;
          end
          if (err_q || (cnt_q + 4'd1 == n_q)) begin
            for (int i = 0; i < PEER_SLOTS; i++) slot_d[i] = '0;
            start_d = 8'd0;
            total_d = {4'd0, iface_cnt};
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < PEER_SLOTS; i++) slot_q[i] <= '0;
      total_q     <= {4'd0, LOCAL_SUBNETS_RST};
      start_q     <= 8'd0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      empty_vld_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      total_q     <= total_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      empty_vld_q <= empty_vld_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    rem_q        <= rem_d;
    empty_idx_q  <= empty_idx_d;
    base_q       <= base_d;
    bits_q       <= bits_d;
    nl_q         <= nl_d;
    err_q        <= err_d;
    idx_q        <= idx_d;
    n_q          <= n_d;
    status_q     <= status_d;
    sub_prefix_q <= sub_prefix_d;
    sub_len_q    <= sub_len_d;
    sub_idx_q    <= sub_idx_d;
    last_q       <= last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign sub_prefix_o        = sub_prefix_q;
  assign sub_prefix_length_o = sub_len_q;
  assign subnet_index_o      = sub_idx_q;
  assign last_o              = last_q;

endmodule

// ===== rtl/ssn_checker.sv =====
// Port-level checks for subnet_split_negotiator_core and the bind that attaches them.
// Depends on ssn_pkg and subnet_split_negotiator_core_defines.svh.
`timescale 1ns / 1ps
`include "subnet_split_negotiator_core_defines.svh"

module ssn_checker
  import ssn_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [63:0] sub_prefix_o,
  input logic [6:0]  sub_prefix_length_o,
  input logic [7:0]  subnet_index_o,
  input logic        last_o
);

  `SSN_ASSERT_NOW(a_err_shape, out_valid_o && status_o == STATUS_ERR, last_o && sub_prefix_o == 64'd0 && sub_prefix_length_o == 7'd0 && subnet_index_o == 8'd0)

  `SSN_ASSERT_NOW(a_ok_length, out_valid_o && status_o == STATUS_OK, sub_prefix_length_o != 7'd0 && sub_prefix_length_o <= 7'd64)

  `SSN_ASSERT_NEXT(a_timeout_busy, in_valid_i && !in_stall_o && op_i == OP_TIMEOUT, in_stall_o)

  `SSN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sub_prefix_o) && $stable(subnet_index_o))

endmodule

bind subnet_split_negotiator_core ssn_checker u_ssn_checker (.*);

// ===== tb/ssn_prefix_checker.sv =====
// Checker for the subnet split negotiator: watches the register port and the request
// and result channels, predicts every sub-prefix result and compares it field by field.
// Depends on ssn_pkg.
`timescale 1ns / 1ps

module ssn_prefix_checker
  import ssn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              op_i,
  input  logic [63:0]       peer_address_i,
  input  logic              peer_accepted_i,
  input  logic [7:0]        remote_subnets_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              status_o,
  input  logic [63:0]       sub_prefix_o,
  input  logic [6:0]        sub_prefix_length_o,
  input  logic [7:0]        subnet_index_o,
  input  logic              last_o,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic        status;
    logic [63:0] prefix;
    logic [6:0]  length;
    logic [7:0]  index;
    logic        last;
  } split_result_t;

  logic [63:0] own_addr_r;
  logic [3:0]  addr_len_r;
  logic [3:0]  local_subnets_r;
  logic [63:0] upstream_r;
  logic [6:0]  prefix_len_r;

  logic [63:0] peer_table [PEER_SLOTS_DEF];
  logic [7:0]  subnet_total;
  logic [7:0]  start_index;

  split_result_t expected_prefixes [$];

  function automatic int clamp_range(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] addr_mask();
    int nb;
    nb = clamp_range(int'(addr_len_r), MAX_ADDR_BYTES_DEF);
    if (nb >= 8) return '1;
    return (64'd1 << (8 * nb)) - 64'd1;
  endfunction

  task automatic clear_round();
    for (int i = 0; i < PEER_SLOTS_DEF; i++) peer_table[i] = '0;
    start_index = '0;
    subnet_total = 8'(clamp_range(int'(local_subnets_r), MAX_DOWNSTREAM_DEF));
  endtask

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors_o++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_OWN_ADDRESS:     own_addr_r = val;
      REG_ADDRESS_LENGTH:  addr_len_r = val[3:0];
      REG_LOCAL_SUBNETS:   local_subnets_r = val[3:0];
      REG_UPSTREAM_PREFIX: upstream_r = val;
      REG_PREFIX_LENGTH:   prefix_len_r = val[6:0];
      default: ;
    endcase
  endtask

  task automatic predict_announce(input logic [63:0] peer, input logic [7:0] count);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] own;
    logic [63:0] s;
    int          empty;
    logic        dup;
    m = addr_mask();
    a = peer & m;
    own = own_addr_r & m;
    empty = -1;
    dup = 1'b0;
    for (int i = 0; i < PEER_SLOTS_DEF; i++) begin
      s = peer_table[i] & m;
      if (s == '0) begin
        empty = i;
      end else if (s == a) begin
        dup = 1'b1;
        break;
      end
    end
    if (dup) return;
    if (empty >= 0) peer_table[empty] = (peer_table[empty] & ~m) | a;
    if (own != a) begin
      subnet_total = subnet_total + count;
      if (own > a) start_index = start_index + count;
    end
  endtask

  task automatic predict_split();
    int            bits;
    int            pl;
    int            nl;
    int            n;
    logic [7:0]    t;
    logic [7:0]    idx;
    logic [63:0]   base;
    logic [63:0]   field;
    split_result_t r;
    t = subnet_total;
    bits = 0;
    while (t != 8'd0) begin
      bits++;
      t = t >> 1;
    end
    pl = int'(prefix_len_r);
    nl = pl + bits;
    if (bits == 0 || nl > 64) begin
      r.status = STATUS_ERR;
      r.prefix = '0;
      r.length = '0;
      r.index  = '0;
      r.last   = 1'b1;
      expected_prefixes.push_back(r);
    end else begin
      base = (pl == 0) ? 64'd0 : (upstream_r & ({64{1'b1}} << (64 - pl)));
      n = clamp_range(int'(local_subnets_r), MAX_DOWNSTREAM_DEF);
      idx = start_index;
      for (int k = 0; k < n; k++) begin
        idx = idx + 8'd1;
        field = {56'd0, idx} & ((64'd1 << bits) - 64'd1);
        r.status = STATUS_OK;
        r.prefix = base | (field << (64 - nl));
        r.length = 7'(nl);
        r.index  = idx;
        r.last   = (k == n - 1);
        expected_prefixes.push_back(r);
      end
    end
    clear_round();
  endtask

  task automatic check_result();
    split_result_t want;
    if (expected_prefixes.size() == 0) begin
      report($sformatf("result with nothing pending: prefix %h/%0d",
                       sub_prefix_o, sub_prefix_length_o));
      return;
    end
    want = expected_prefixes.pop_front();
    if (status_o !== want.status)
      report($sformatf("status got %b, expected %b", status_o, want.status));
    if (sub_prefix_o !== want.prefix)
      report($sformatf("sub_prefix got %h, expected %h", sub_prefix_o, want.prefix));
    if (sub_prefix_length_o !== want.length)
      report($sformatf("sub_prefix_length got %0d, expected %0d",
                       sub_prefix_length_o, want.length));
    if (subnet_index_o !== want.index)
      report($sformatf("subnet_index got %0d, expected %0d", subnet_index_o, want.index));
    if (last_o !== want.last)
      report($sformatf("last got %b, expected %b", last_o, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_r      = '0;
      addr_len_r      = ADDRESS_LENGTH_RST;
      local_subnets_r = LOCAL_SUBNETS_RST;
      upstream_r      = '0;
      prefix_len_r    = PREFIX_LENGTH_RST;
      clear_round();
      expected_prefixes.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (psel && penable && pwrite && pready) write_reg(paddr[CFG_AW-1:3], pwdata);
      if (in_valid_i && !in_stall_o) begin
        if (op_i == OP_TIMEOUT) predict_split();
        else if (peer_accepted_i) predict_announce(peer_address_i, remote_subnets_i);
      end
      pending_o = expected_prefixes.size();
    end
  end

endmodule

// ===== tb/subnet_split_negotiator_core_tb.sv =====
// Top of the subnet split negotiator testbench: clock, reset, register writes,
// request stimulus and receiver stalls; gives the verdict from ssn_prefix_checker.
// Depends on ssn_pkg, subnet_split_negotiator_core and ssn_prefix_checker.
`timescale 1ns / 1ps

module subnet_split_negotiator_core_tb;
  import ssn_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 195;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              op_i;
  logic [63:0]       peer_address_i;
  logic              peer_accepted_i;
  logic [7:0]        remote_subnets_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              status_o;
  logic [63:0]       sub_prefix_o;
  logic [6:0]        sub_prefix_length_o;
  logic [7:0]        subnet_index_o;
  logic              last_o;

  int errors;
  int pending;

  int          send_idle  = 0;
  int          stall_pct  = 0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int          items_sent = 0;
  logic [63:0] own_cur    = '0;

  subnet_split_negotiator_core uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .peer_address_i, .peer_accepted_i,
    .remote_subnets_i, .out_valid_o, .out_stall_i, .status_o, .sub_prefix_o,
    .sub_prefix_length_o, .subnet_index_o, .last_o
  );

  ssn_prefix_checker prefix_check (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .peer_address_i, .peer_accepted_i,
    .remote_subnets_i, .out_valid_o, .out_stall_i, .status_o, .sub_prefix_o,
    .sub_prefix_length_o, .subnet_index_o, .last_o,
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("subnet_split_negotiator_core_tb: done, errors");
    $finish;
  end

  task automatic set_idle(input int phase);
    case (phase)
      0: begin send_idle = 0;  stall_pct = 0;  end
      1: begin send_idle = 49; stall_pct = 0;  end
      2: begin send_idle = 0;  stall_pct = 49; end
      default: begin send_idle = 20; stall_pct = 20; end
    endcase
  endtask

  task automatic send_req(input logic op, input logic [63:0] addr, input logic acc,
                          input logic [7:0] count);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    peer_address_i   <= addr;
    peer_accepted_i  <= acc;
    remote_subnets_i <= count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_OWN_ADDRESS) own_cur = val;
  endtask

  // stop sending, wait out every pending result and the tail of the last request
  task automatic drain();
    int waited;
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [3:0] pick_size();
    if ($urandom_range(99) < 10)
      return ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
    return 4'($urandom_range(8, 1));
  endfunction

  task automatic random_config();
    logic [63:0] junk;
    logic [6:0]  pl;
    int          r;
    junk = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 15)      pl = 7'($urandom_range(31, 0));
    else if (r < 75) pl = 7'($urandom_range(60, 32));
    else if (r < 85) pl = 7'($urandom_range(64, 61));
    else             pl = 7'($urandom_range(127, 65));
    reg_write(REG_OWN_ADDRESS, {$urandom, $urandom});
    reg_write(REG_ADDRESS_LENGTH, {junk[63:4], pick_size()});
    reg_write(REG_LOCAL_SUBNETS, {junk[63:4], pick_size()});
    reg_write(REG_UPSTREAM_PREFIX, {$urandom, $urandom});
    reg_write(REG_PREFIX_LENGTH, {junk[63:7], pl});
  endtask

  // one negotiation: announcements, mostly from a small peer pool, with occasional timeouts, then a timeout
  task automatic run_round();
    logic [63:0] pool [6];
    int          n;
    int          r;
    logic [7:0]  rs;
    for (int j = 0; j < 4; j++)
      pool[j] = ($urandom_range(99) < 30) ? 64'($urandom_range(255)) : {$urandom, $urandom};
    if ($urandom_range(99) < 15) pool[1] = '0;
    pool[4] = own_cur;
    pool[5] = pool[0] ^ {$urandom, 32'd0};
    n = $urandom_range(7, 0);
    repeat (n) begin
      r = $urandom_range(99);
      rs = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom);
      if (r < 8)       send_req(OP_ANNOUNCE, {$urandom, $urandom}, 1'b0, rs);
      else if (r < 12) send_req(OP_TIMEOUT, {$urandom, $urandom}, 1'($urandom), rs);
      else             send_req(OP_ANNOUNCE, pool[3'($urandom_range(5))], 1'b1, rs);
    end
    send_req(OP_TIMEOUT, {$urandom, $urandom}, 1'($urandom), 8'($urandom));
  endtask

  initial begin
    int round;
    int random_start;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    op_i             <= OP_ANNOUNCE;
    peer_address_i   <= '0;
    peer_accepted_i  <= 1'b0;
    remote_subnets_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_idle(0);
    reg_write(REG_OWN_ADDRESS, 64'h8000_0000_0000_0000);
    reg_write(REG_ADDRESS_LENGTH, 64'd8);
    reg_write(REG_LOCAL_SUBNETS, 64'd8);
    reg_write(REG_UPSTREAM_PREFIX, 64'h2001_0db8_85a3_ffff);
    reg_write(REG_PREFIX_LENGTH, 64'd48);
    // total still from reset, eight interfaces overflow a one-bit index
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);
    send_req(OP_ANNOUNCE, 64'd1, 1'b1, 8'd3);
    send_req(OP_ANNOUNCE, 64'd1, 1'b1, 8'd200);
    send_req(OP_ANNOUNCE, 64'd2, 1'b0, 8'd50);
    send_req(OP_ANNOUNCE, own_cur, 1'b1, 8'd7);
    send_req(OP_ANNOUNCE, 64'd0, 1'b1, 8'd1);
    send_req(OP_ANNOUNCE, '1, 1'b1, 8'd2);
    send_req(OP_ANNOUNCE, 64'd3, 1'b1, 8'd1);
    send_req(OP_ANNOUNCE, 64'd4, 1'b1, 8'd255);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);
    // wrap the total to zero
    send_req(OP_ANNOUNCE, 64'd5, 1'b1, 8'd248);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);

    drain();
    reg_write(REG_OWN_ADDRESS, 64'hffff_ffff_ffff_ff10);
    reg_write(REG_ADDRESS_LENGTH, 64'd1);
    reg_write(REG_LOCAL_SUBNETS, 64'd15);
    reg_write(REG_PREFIX_LENGTH, 64'd64);
    send_req(OP_ANNOUNCE, 64'h1234_5678_9abc_de05, 1'b1, 8'd1);
    send_req(OP_ANNOUNCE, 64'h0000_0000_0000_0105, 1'b1, 8'd9);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);

    drain();
    reg_write(REG_ADDRESS_LENGTH, 64'd0);
    reg_write(REG_LOCAL_SUBNETS, 64'd0);
    reg_write(REG_PREFIX_LENGTH, 64'd127);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);

    drain();
    reg_write(REG_ADDRESS_LENGTH, 64'd15);
    reg_write(REG_LOCAL_SUBNETS, 64'd1);
    reg_write(REG_UPSTREAM_PREFIX, '1);
    reg_write(REG_PREFIX_LENGTH, 64'd0);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);
    send_req(OP_ANNOUNCE, '1, 1'b1, 8'hff);
    send_req(OP_TIMEOUT, '1, 1'b1, 8'hff);

    drain();
    reg_write(REG_LOCAL_SUBNETS, 64'd8);
    reg_write(REG_PREFIX_LENGTH, 64'd62);
    send_req(OP_ANNOUNCE, 64'd7, 1'b1, 8'd1);
    send_req(OP_TIMEOUT, '0, 1'b0, 8'd0);
    drain();

    round = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      set_idle(round % 4);
      if (round % 6 == 5) begin
        drain();
        random_config();
      end
      if (round == 2) begin
        drain();
        reg_write(REG_LOCAL_SUBNETS, 64'd8);
        hold_req++;
      end
      run_round();
      round++;
    end

    drain();
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("subnet_split_negotiator_core_tb: done, clean");
    end else begin
      $display("subnet_split_negotiator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
